/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define TSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("task_slot_pool assertion failed");

// Property checked at every clock edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("task_slot_pool assertion failed");

`else

`define TSP_ASSERT(lbl, clk, rst_n, prop)
`define TSP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* sv/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the task slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    localparam int SLOTS        = 16;
    localparam int HANDLE_WIDTH = 32;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OCC_W  = $clog2(SLOTS + 1);

    // Transaction field widths.
    localparam int FUNC_W     = 2;
    localparam int HANDLE_IN_W = 32;
    localparam int CREDIT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int TASK_W     = 32;
    localparam int SLOT_IDX_W = 4;
    localparam int OCC_OUT_W  = 5;
    localparam int COUNT_W    = 32;
    localparam int THR_W      = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_CREDIT = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Request from the top level to the slot allocator.
    typedef struct packed {
        logic take;     // occupy lowest free slot
        logic release_; // free lowest occupied slot
    } alloc_req_t;

    // Lookup result of the allocator, valid in the current cycle.
    typedef struct packed {
        logic              free_hit;
        logic [SLOT_W-1:0] free_idx;
        logic              used_hit;
        logic [SLOT_W-1:0] used_idx;
    } alloc_rsp_t;

endpackage

`default_nettype wire

/* sv/tsp_if.sv */
// ----------------------------------------------------------------------------
// Task slot pool channels
// Request and response handshake interfaces (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface tsp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] task_handle;
    logic [15:0] outside_count;

    modport source (output valid, output func, output task_handle,
                    output outside_count, input ready);
    modport sink   (input valid, input func, input task_handle,
                    input outside_count, output ready);
endinterface

interface tsp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] task_out;
    logic [3:0]  slot_index;
    logic [4:0]  occupancy;
    logic [31:0] inserted_total;
    logic [31:0] processed_total;
    logic        enough_buffered;

    modport source (output valid, output status, output task_out,
                    output slot_index, output occupancy, output inserted_total,
                    output processed_total, output enough_buffered, input ready);
    modport sink   (input valid, input status, input task_out,
                    input slot_index, input occupancy, input inserted_total,
                    input processed_total, input enough_buffered, output ready);
endinterface

`default_nettype wire

/* sv/tsp_ram.sv */
// ----------------------------------------------------------------------------
// tsp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/tsp_alloc.sv */
// ----------------------------------------------------------------------------
// tsp_alloc
// Slot valid bits, first-free / first-used search and occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_alloc
    import tsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire alloc_req_t req,
    output alloc_rsp_t      rsp,
    output logic [OCC_W-1:0] occ
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    // Priority search, lowest index wins.
    always_comb
    begin
        rsp = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                rsp.free_hit = 1'b1;
                rsp.free_idx = SLOT_W'(i);
            end
            if (valid_reg[i])
            begin
                rsp.used_hit = 1'b1;
                rsp.used_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (req.take && rsp.free_hit)
        begin
            valid_next[rsp.free_idx] = 1'b1;
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (req.release_ && rsp.used_hit)
        begin
            valid_next[rsp.used_idx] = 1'b0;
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    assign occ = occ_reg;

endmodule

`default_nettype wire

/* sv/task_slot_pool.sv */
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle; the slot search and counter updates
// finish in the accept cycle and the handle RAM read completes the next.
// A waiting result stalls new requests only while the response is not taken.
// Reset (rst_n, async low): all slots free, totals and threshold zero;
// the handle RAM is not cleared, a slot is read only after it was written.
// ----------------------------------------------------------------------------
// task_slot_pool
// Pool of task slots with lowest-free allocation and lowest-used removal.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module task_slot_pool
    import tsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    tsp_req_if.sink               req,
    tsp_rsp_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [THR_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Handshake: the response register is the only buffer. A new request
    // is taken when it is empty or being drained in the same cycle.
    // ------------------------------------------------------------------
    logic accept;
    logic rsp_valid_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Configuration register.
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Decode and slot allocation.
    // ------------------------------------------------------------------
    logic       is_add;
    logic       is_get;
    logic       is_credit;
    alloc_req_t a_req;
    alloc_rsp_t a_rsp;
    logic [OCC_W-1:0] occ;
    logic       add_ok;
    logic       get_ok;

    assign is_add    = (req.func == FUNC_ADD);
    assign is_get    = (req.func == FUNC_GET);
    assign is_credit = (req.func == FUNC_CREDIT);

    assign a_req.take     = accept && is_add;
    assign a_req.release_ = accept && is_get;

    assign add_ok = a_req.take && a_rsp.free_hit;
    assign get_ok = a_req.release_ && a_rsp.used_hit;

    tsp_alloc u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (a_req),
        .rsp   (a_rsp),
        .occ   (occ)
    );

    // ------------------------------------------------------------------
    // Handle storage. Write on a successful add, read on a successful get;
    // read data lands with the response and holds until the next get.
    // A get in the cycle after an add to the same slot reads the new data
    // since the write has already completed at that edge.
    // ------------------------------------------------------------------
    logic [HANDLE_WIDTH-1:0] rdata;

    tsp_ram #(
        .DEPTH (SLOTS),
        .WIDTH (HANDLE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (add_ok),
        .waddr (a_rsp.free_idx),
        .wdata (HANDLE_WIDTH'(req.task_handle)),
        .re    (get_ok),
        .raddr (a_rsp.used_idx),
        .rdata (rdata)
    );

    // ------------------------------------------------------------------
    // Totals and response register. The totals themselves serve as the
    // response fields: they only change on accept, which implies the
    // previous response was already taken.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] ins_cnt_reg;
    logic [COUNT_W-1:0] ins_cnt_next;
    logic [COUNT_W-1:0] proc_cnt_reg;
    logic [COUNT_W-1:0] proc_cnt_next;
    status_t            status_reg;
    status_t            status_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               get_ok_reg;
    logic               rsp_valid_next;

    always_comb
    begin
        ins_cnt_next   = ins_cnt_reg;
        proc_cnt_next  = proc_cnt_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            slot_next      = '0;
            if (is_add)
            begin
                if (add_ok)
                begin
                    ins_cnt_next = ins_cnt_reg + COUNT_W'(1);
                    slot_next    = a_rsp.free_idx;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else if (is_get)
            begin
                if (get_ok)
                begin
                    proc_cnt_next = proc_cnt_reg + COUNT_W'(1);
                    slot_next     = a_rsp.used_idx;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            else if (is_credit)
            begin
                proc_cnt_next = proc_cnt_reg + COUNT_W'(req.outside_count);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            ins_cnt_reg   <= '0;
            proc_cnt_reg  <= '0;
            status_reg    <= ST_OK;
            slot_reg      <= '0;
            get_ok_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            ins_cnt_reg   <= ins_cnt_next;
            proc_cnt_reg  <= proc_cnt_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            if (accept)
            begin
                get_ok_reg <= get_ok;
            end
        end
    end

    // Threshold of zero means at least one task buffered.
    logic enough;

    assign enough = (thr_reg == '0) ? (occ != '0) : (32'(occ) >= 32'(thr_reg));

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.task_out        = get_ok_reg ? TASK_W'(rdata) : '0;
    assign rsp.slot_index      = SLOT_IDX_W'(slot_reg);
    assign rsp.occupancy       = OCC_OUT_W'(occ);
    assign rsp.inserted_total  = ins_cnt_reg;
    assign rsp.processed_total = proc_cnt_reg;
    assign rsp.enough_buffered = enough;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TSP_ASSERT(a_occ_range, clk, rst_n, 32'(occ) <= SLOTS)
    `TSP_ASSERT(a_full_means_full, clk, rst_n, (rsp_valid_reg && status_reg == ST_FULL) |-> (32'(occ) == SLOTS))
    `TSP_ASSERT(a_add_counts, clk, rst_n, add_ok |=> (ins_cnt_reg == $past(ins_cnt_reg) + COUNT_W'(1)) && (occ == $past(occ) + OCC_W'(1)))
    `TSP_ASSERT(a_empty_means_empty, clk, rst_n, (rsp_valid_reg && status_reg == ST_EMPTY) |-> (occ == '0))

endmodule

`default_nettype wire
